// ===== rtl/uart_16550_register_block_assert.svh =====
// ----------------------------------------------------------------------------
// uart register block assertion macros
// shared property forms for the uart register block checkers
// ----------------------------------------------------------------------------
`ifndef UART_16550_REGISTER_BLOCK_ASSERT_SVH
`define UART_16550_REGISTER_BLOCK_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define URB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define URB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uart_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// uart register block package
// transfer types, function codes, register offsets and fixed register values
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  // function codes of one input transfer
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_RX    = 2'd2;

  // register offsets
  localparam logic [2:0] OFF_RBR = 3'd0;
  localparam logic [2:0] OFF_IER = 3'd1;
  localparam logic [2:0] OFF_IIR = 3'd2;
  localparam logic [2:0] OFF_LCR = 3'd3;
  localparam logic [2:0] OFF_MCR = 3'd4;
  localparam logic [2:0] OFF_LSR = 3'd5;
  localparam logic [2:0] OFF_MSR = 3'd6;
  localparam logic [2:0] OFF_SCR = 3'd7;

  // bit positions
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned IER_RDA_BIT  = 0;
  localparam int unsigned IER_THRE_BIT = 1;

  // fixed read values
  localparam logic [7:0] IIR_NONE       = 8'hC1;
  localparam logic [7:0] IIR_THRE       = 8'hC2;
  localparam logic [7:0] IIR_RDA        = 8'hC4;
  localparam logic [7:0] LSR_TX_IDLE    = 8'h60;
  localparam logic [7:0] LSR_DATA_READY = 8'h01;
  localparam logic [7:0] MSR_VALUE      = 8'hB0;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] offset;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
  } uart_rb_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_request;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } uart_rb_out_t;

endpackage

// ===== rtl/uart_16550_register_block.sv =====
// ----------------------------------------------------------------------------
// uart 16550 register block
// register model of a fifo-less 16550-style uart: bus reads and writes plus
// received byte arrivals, one result transfer per input transfer
// ----------------------------------------------------------------------------
//  channel | ports                           | carries
//  --------+---------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data     | func, offset, wdata, rx_byte
//  result  | out_valid, out_ready, out_data  | rdata, irq_request, tx_valid,
//          |                                 | tx_byte
//
//  one transfer per cycle while the result is not stalled; the result appears
//  in the cycle after acceptance, held in the single register stage between
//  the decode logic and out_data. in_ready stays high while the result
//  register is empty or being drained, so a stalled result holds off only the
//  next input transfer. rst_n (synchronous) clears all uart registers, flags
//  and the result valid.
module uart_16550_register_block
  import uart_rb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  uart_rb_in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output uart_rb_out_t out_data
);

  logic [7:0]   lcr_r, lcr_nxt;
  logic [7:0]   ier_r, ier_nxt;
  logic [7:0]   mcr_r, mcr_nxt;
  logic [7:0]   scr_r, scr_nxt;
  logic [7:0]   dll_r, dll_nxt;
  logic [7:0]   dlm_r, dlm_nxt;
  logic [7:0]   rbr_r, rbr_nxt;
  logic         rx_full_r, rx_full_nxt;
  logic         thre_pend_r, thre_pend_nxt;
  logic         out_valid_r, out_valid_nxt;
  uart_rb_out_t out_data_r, out_data_nxt;
  logic         in_xfer;
  logic         dlab;

  // input taken whenever the result slot is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign dlab      = lcr_r[LCR_DLAB_BIT];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // register access decode and flag updates
  always_comb begin
    lcr_nxt       = lcr_r;
    ier_nxt       = ier_r;
    mcr_nxt       = mcr_r;
    scr_nxt       = scr_r;
    dll_nxt       = dll_r;
    dlm_nxt       = dlm_r;
    rbr_nxt       = rbr_r;
    rx_full_nxt   = rx_full_r;
    thre_pend_nxt = thre_pend_r;
    out_data_nxt  = '0;
    if (in_xfer) begin
      unique case (in_data.func)
        FUNC_READ: begin
          unique case (in_data.offset)
            OFF_RBR: begin
              if (dlab) begin
                out_data_nxt.rdata = dll_r;
              end else if (rx_full_r) begin
                out_data_nxt.rdata = rbr_r;
                rx_full_nxt        = 1'b0;
              end
            end
            OFF_IER: out_data_nxt.rdata = dlab ? dlm_r : ier_r;
            OFF_IIR: begin
              // received data outranks thre; reporting thre clears it
              if (rx_full_r && ier_r[IER_RDA_BIT]) begin
                out_data_nxt.rdata = IIR_RDA;
              end else if (thre_pend_r && ier_r[IER_THRE_BIT]) begin
                out_data_nxt.rdata = IIR_THRE;
                thre_pend_nxt      = 1'b0;
              end else begin
                out_data_nxt.rdata = IIR_NONE;
              end
            end
            OFF_LCR: out_data_nxt.rdata = lcr_r;
            OFF_MCR: out_data_nxt.rdata = mcr_r;
            OFF_LSR: out_data_nxt.rdata = LSR_TX_IDLE |
                                          (rx_full_r ? LSR_DATA_READY : 8'h00);
            OFF_MSR: out_data_nxt.rdata = MSR_VALUE;
            OFF_SCR: out_data_nxt.rdata = scr_r;
          endcase
        end
        FUNC_WRITE: begin
          unique case (in_data.offset)
            OFF_RBR: begin
              if (dlab) begin
                dll_nxt = in_data.wdata;
              end else begin
                // transmit holding write
                out_data_nxt.tx_valid    = 1'b1;
                out_data_nxt.tx_byte     = in_data.wdata;
                out_data_nxt.irq_request = ier_r[IER_THRE_BIT];
                thre_pend_nxt            = 1'b1;
              end
            end
            OFF_IER: begin
              if (dlab) begin
                dlm_nxt = in_data.wdata;
              end else begin
                ier_nxt = in_data.wdata;
                if (in_data.wdata[IER_THRE_BIT]) begin
                  thre_pend_nxt            = 1'b1;
                  out_data_nxt.irq_request = 1'b1;
                end else if (in_data.wdata[IER_RDA_BIT] && rx_full_r) begin
                  out_data_nxt.irq_request = 1'b1;
                end
              end
            end
            OFF_LCR: lcr_nxt = in_data.wdata;
            OFF_MCR: mcr_nxt = in_data.wdata;
            OFF_SCR: scr_nxt = in_data.wdata;
            // fifo control and status offsets ignore writes
            default: ;
          endcase
        end
        FUNC_RX: begin
          // byte arriving at a full buffer is dropped
          if (!rx_full_r) begin
            rbr_nxt                  = in_data.rx_byte;
            rx_full_nxt              = 1'b1;
            out_data_nxt.irq_request = ier_r[IER_RDA_BIT];
          end
        end
        // unused code: all-zero result, no change
        default: ;
      endcase
    end
  end

  // result slot valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // uart state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcr_r       <= '0;
      ier_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      dll_r       <= '0;
      dlm_r       <= '0;
      rbr_r       <= '0;
      rx_full_r   <= 1'b0;
      thre_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lcr_r       <= lcr_nxt;
      ier_r       <= ier_nxt;
      mcr_r       <= mcr_nxt;
      scr_r       <= scr_nxt;
      dll_r       <= dll_nxt;
      dlm_r       <= dlm_nxt;
      rbr_r       <= rbr_nxt;
      rx_full_r   <= rx_full_nxt;
      thre_pend_r <= thre_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== rtl/uart_rb_checker.sv =====
// ----------------------------------------------------------------------------
// uart register block checker
// port-level checks on result timing and fixed read values, bound to the top
// ----------------------------------------------------------------------------
`include "uart_16550_register_block_assert.svh"

module uart_rb_sva
  import uart_rb_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input uart_rb_in_t  in_data,
  input logic         out_valid,
  input logic         out_ready,
  input uart_rb_out_t out_data
);

  logic rd_msr;
  logic rd_iir;
  logic no_tx;
  logic iir_ok;

  // classify accepted input transfers
  assign rd_msr = in_valid && in_ready && (in_data.func == FUNC_READ) &&
                  (in_data.offset == OFF_MSR);
  assign rd_iir = in_valid && in_ready && (in_data.func == FUNC_READ) &&
                  (in_data.offset == OFF_IIR);
  assign no_tx  = in_valid && in_ready && (in_data.func != FUNC_WRITE);

  // result data holds one of the three identification codes
  assign iir_ok = (out_data.rdata == IIR_NONE) || (out_data.rdata == IIR_THRE) ||
                  (out_data.rdata == IIR_RDA);

  // a stalled result holds
  `URB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // modem status read returns the fixed line state next cycle
  `URB_ASSERT_NEXT(a_msr_value, rd_msr, out_valid && (out_data.rdata == MSR_VALUE), "bad msr read")

  // interrupt identification is one of the three codes
  `URB_ASSERT_NEXT(a_iir_code, rd_iir, out_valid && iir_ok, "bad iir code")

  // only a write can transmit
  `URB_ASSERT_NEXT(a_tx_only_write, no_tx, out_valid && !out_data.tx_valid, "transmit without write")

endmodule

bind uart_16550_register_block uart_rb_sva u_uart_rb_sva (.*);

// ===== verif/uart_rb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart register block checker
// watches both channels of the uart register block, keeps its own copy of
// the uart registers and flags, works out the result of every accepted input
// transfer and compares each result transfer with the oldest expected one
// ----------------------------------------------------------------------------
module uart_rb_checker
  import uart_rb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  uart_rb_in_t  in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  uart_rb_out_t out_data,
  output int           fail_count,
  output int           pending_count,
  output int           checked_count
);

  // shadow copy of the uart registers
  logic [7:0] lcr_q;
  logic [7:0] ier_q;
  logic [7:0] mcr_q;
  logic [7:0] scr_q;
  logic [7:0] dll_q;
  logic [7:0] dlm_q;
  logic [7:0] rbr_q;
  logic       data_ready_q;
  logic       thre_pending_q;

  // results still owed by the block, oldest first
  uart_rb_out_t uart_results_q[$];

  // next result of one input transfer, updating the shadow registers
  task automatic predict_uart_result(input uart_rb_in_t t, output uart_rb_out_t r);
    logic dlab;
    r    = '0;
    dlab = lcr_q[LCR_DLAB_BIT];
    case (t.func)
      FUNC_READ: begin
        case (t.offset)
          OFF_RBR: begin
            if (dlab) begin
              r.rdata = dll_q;
            end else if (data_ready_q) begin
              r.rdata      = rbr_q;
              data_ready_q = 1'b0;
            end
          end
          OFF_IER: r.rdata = dlab ? dlm_q : ier_q;
          OFF_IIR: begin
            // received data outranks thre; a reported thre is consumed
            if (data_ready_q && ier_q[IER_RDA_BIT]) begin
              r.rdata = IIR_RDA;
            end else if (thre_pending_q && ier_q[IER_THRE_BIT]) begin
              r.rdata        = IIR_THRE;
              thre_pending_q = 1'b0;
            end else begin
              r.rdata = IIR_NONE;
            end
          end
          OFF_LCR: r.rdata = lcr_q;
          OFF_MCR: r.rdata = mcr_q;
          OFF_LSR: r.rdata = LSR_TX_IDLE | (data_ready_q ? LSR_DATA_READY : 8'h00);
          OFF_MSR: r.rdata = MSR_VALUE;
          default: r.rdata = scr_q;
        endcase
      end
      FUNC_WRITE: begin
        case (t.offset)
          OFF_RBR: begin
            if (dlab) begin
              dll_q = t.wdata;
            end else begin
              r.tx_valid     = 1'b1;
              r.tx_byte      = t.wdata;
              thre_pending_q = 1'b1;
              r.irq_request  = ier_q[IER_THRE_BIT];
            end
          end
          OFF_IER: begin
            if (dlab) begin
              dlm_q = t.wdata;
            end else begin
              ier_q = t.wdata;
              if (t.wdata[IER_THRE_BIT]) begin
                thre_pending_q = 1'b1;
                r.irq_request  = 1'b1;
              end else if (t.wdata[IER_RDA_BIT] && data_ready_q) begin
                r.irq_request = 1'b1;
              end
            end
          end
          OFF_LCR: lcr_q = t.wdata;
          OFF_MCR: mcr_q = t.wdata;
          OFF_SCR: scr_q = t.wdata;
          default: ;
        endcase
      end
      FUNC_RX: begin
        // a byte arriving on a full buffer is lost
        if (!data_ready_q) begin
          rbr_q         = t.rx_byte;
          data_ready_q  = 1'b1;
          r.irq_request = ier_q[IER_RDA_BIT];
        end
      end
      default: ;
    endcase
  endtask

  // compare result transfers, then queue the prediction for an input transfer
  always @(posedge clk) begin
    uart_rb_out_t want;
    uart_rb_out_t pred;
    if (!rst_n) begin
      lcr_q          = '0;
      ier_q          = '0;
      mcr_q          = '0;
      scr_q          = '0;
      dll_q          = '0;
      dlm_q          = '0;
      rbr_q          = '0;
      data_ready_q   = 1'b0;
      thre_pending_q = 1'b0;
      uart_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (uart_results_q.size() == 0) begin
          $display("%0t: result transfer with none expected, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = uart_results_q.pop_front();
          checked_count++;
          if (out_data.rdata !== want.rdata) begin
            $display("%0t: rdata expected %02h, got %02h", $time, want.rdata, out_data.rdata);
            fail_count++;
          end
          if (out_data.irq_request !== want.irq_request) begin
            $display("%0t: irq_request expected %b, got %b", $time, want.irq_request,
                     out_data.irq_request);
            fail_count++;
          end
          if (out_data.tx_valid !== want.tx_valid) begin
            $display("%0t: tx_valid expected %b, got %b", $time, want.tx_valid,
                     out_data.tx_valid);
            fail_count++;
          end
          if (out_data.tx_byte !== want.tx_byte) begin
            $display("%0t: tx_byte expected %02h, got %02h", $time, want.tx_byte,
                     out_data.tx_byte);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_uart_result(in_data, pred);
        uart_results_q.push_back(pred);
      end
    end
    pending_count = uart_results_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart register block testbench
// drives bus reads, bus writes, received bytes and unused codes into the uart register
// block with random gaps and result stalls; a directed opening walks the
// register map and interrupt flags, then random phases follow
// ----------------------------------------------------------------------------
module tb;
  import uart_rb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         N_RANDOM    = 1200;
  localparam int         N_PHASES    = 4;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  uart_rb_in_t  in_data;
  logic         out_valid;
  logic         out_ready = 1'b0;
  uart_rb_out_t out_data;

  int fail_count;
  int pending_count;
  int checked_count;

  bit in_gaps_on;
  bit out_stalls_on;
  int stall_left = 0;
  int n_read;
  int n_write;
  int n_rx;
  int n_unused;

  uart_rb_in_t directed_seq[$];

  uart_16550_register_block u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  uart_rb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short idle spells, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic uart_rb_in_t uart_op(logic [1:0] f, logic [2:0] o, logic [7:0] w,
                                          logic [7:0] rx);
    return '{func: f, offset: o, wdata: w, rx_byte: rx};
  endfunction

  function automatic uart_rb_in_t random_uart_op();
    uart_rb_in_t t;
    int          pick;
    t.offset  = 3'($urandom_range(0, 7));
    t.wdata   = 8'($urandom_range(0, 255));
    t.rx_byte = 8'($urandom_range(0, 255));
    pick      = $urandom_range(0, 99);
    if (pick < 40)      t.func = FUNC_READ;
    else if (pick < 75) t.func = FUNC_WRITE;
    else if (pick < 95) t.func = FUNC_RX;
    else                t.func = FUNC_UNUSED;
    // keep dlab clear most of the time so the data and interrupt path stays in reach
    if (t.func == FUNC_WRITE && t.offset == OFF_LCR && $urandom_range(0, 2) != 0)
      t.wdata[LCR_DLAB_BIT] = 1'b0;
    return t;
  endfunction

  // one input transfer, then an optional idle spell
  task automatic send_uart_op(input uart_rb_in_t t);
    int gap;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    case (t.func)
      FUNC_READ:  n_read++;
      FUNC_WRITE: n_write++;
      FUNC_RX:    n_rx++;
      default:    n_unused++;
    endcase
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = gap_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;

    // interrupt identification, thre and receive buffer handling
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_IIR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_IER, 8'h03, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_IIR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_IIR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_RX,    OFF_RBR, 8'h00, 8'hFF));
    directed_seq.push_back(uart_op(FUNC_RX,    OFF_SCR, 8'hFF, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_LSR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_IIR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_IER, 8'h01, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_RBR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_RBR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_RBR, 8'hA5, 8'h00));
    // divisor latch behind dlab
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_LCR, 8'h80, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_RBR, 8'hFF, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_IER, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_RBR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_IER, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_LCR, 8'h7F, 8'h00));
    // status and fifo control writes have no effect, then modem control, scratch and an unused code
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_LSR, 8'hFF, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_MSR, 8'hFF, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_IIR, 8'hFF, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_MCR, 8'hFF, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_MCR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_MSR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_WRITE, OFF_SCR, 8'h5A, 8'h00));
    directed_seq.push_back(uart_op(FUNC_READ,  OFF_SCR, 8'h00, 8'h00));
    directed_seq.push_back(uart_op(FUNC_UNUSED, OFF_SCR, 8'hFF, 8'hFF));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_seq[i]) send_uart_op(directed_seq[i]);

    // random phases, each with its own mix of gaps and stalls
    for (int p = 0; p < N_PHASES; p++) begin
      in_gaps_on    = (p == 0) || (p == 2);
      out_stalls_on = (p == 0) || (p == 3);
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) send_uart_op(random_uart_op());
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);

    $display("sent %0d transfers: %0d reads, %0d writes, %0d received bytes, %0d unused codes",
             n_read + n_write + n_rx + n_unused, n_read, n_write, n_rx, n_unused);
    $display("checked %0d results over four gap and stall mixes", checked_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_count);
    $display("status: fail");
    $finish;
  end

endmodule
